/* rtl/core/gate_interval_speed_calc_macros.svh */
// Assertion macros for the gate interval speed calculator.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef GATE_INTERVAL_SPEED_CALC_MACROS_SVH
`define GATE_INTERVAL_SPEED_CALC_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define GISC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define GISC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/gisc_pkg.sv */
// Shared types and constants for the gate interval speed calculator.
// No dependencies; imported by every module of the block.
`default_nettype none

package gisc_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int SLOT_W       = $clog2(SENSOR_COUNT);
    localparam int TRIG_W       = $clog2(SENSOR_COUNT + 1);
    localparam int TRIG_SUM_W   = TRIG_W + 1;

    localparam int TS_W      = 32;
    localparam int SPACING_W = 16;
    localparam int MPHQ_W    = 20;
    localparam int SPD_W     = 24;
    localparam int IVL_CNT_W = 5;
    localparam int SUM_W     = 32;

    localparam int                US_W     = 20;
    localparam logic [US_W-1:0]   US_PER_S = 20'd1000000;

    // spacing * 1e6, then times the Q16 factor in two halves
    localparam int NUM_W     = SPACING_W + US_W;
    localparam int HALF_W    = NUM_W / 2;
    localparam int HI_W      = NUM_W - HALF_W;
    localparam int PP_W      = HI_W + MPHQ_W;
    localparam int PROD_W    = NUM_W + MPHQ_W;
    localparam int MPH_SHIFT = 8;

    localparam int DIV_N_W    = PROD_W - MPH_SHIFT;
    localparam int DIV_D_W    = TS_W;
    localparam int DIV_Q_W    = SPD_W;
    localparam int DIV_STEP_W = $clog2(DIV_Q_W + 1);

    localparam int                   CFG_IDX_W   = 4;
    localparam int                   CFG_W       = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MPH     = 4'd1;

    localparam logic [SPACING_W-1:0] SPACING_RST = 16'd100;
    localparam logic [MPHQ_W-1:0]    MPHQ_RST    = 20'd12769;

    typedef struct packed {
        logic [TS_W-1:0] timestamp_us;
        logic            sensor_triggered;
        logic            travel_b_to_a;
    } in_t;

    typedef struct packed {
        logic                 is_summary;
        logic [TS_W-1:0]      interval_us;
        logic [SPD_W-1:0]     speed_mm_per_s;
        logic [SPD_W-1:0]     scale_mph_x256;
        logic [IVL_CNT_W-1:0] interval_count;
        logic [SPD_W-1:0]     avg_mph_x256;
        logic                 run_ok;
        logic                 last_result;
    } out_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] numer;
        logic [DIV_D_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic            en;
        logic [TS_W-1:0] ts;
        logic            fired;
    } store_wr_t;

    typedef struct packed {
        logic              at_last;
        logic [TRIG_W-1:0] trig_count;
    } store_stat_t;

endpackage

`default_nettype wire

/* rtl/core/gisc_div.sv */
// Shared restoring divider, one quotient bit per cycle, saturating at 24 bits.
// Depends on gisc_pkg.
`default_nettype none

module gisc_div
    import gisc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                  busy_reg;
    logic                  sat_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [DIV_D_W-1:0]    rem_reg;
    logic [DIV_D_W-1:0]    den_reg;
    logic [DIV_Q_W-1:0]    nlo_reg;
    logic [DIV_Q_W-1:0]    quot_reg;

    logic                  done;
    logic [DIV_D_W:0]      trial;
    logic [DIV_D_W:0]      diff;
    logic                  ge;

    assign done  = busy_reg && (sat_reg || (step_reg == '0));
    assign trial = {rem_reg, nlo_reg[DIV_Q_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    assign rsp.busy = busy_reg;
    assign rsp.done = done;
    assign rsp.quot = sat_reg ? '1 : quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sat_reg  <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            // quotient overflows 24 bits when the upper numerator part reaches the divisor
            sat_reg  <= DIV_D_W'(req.numer[DIV_N_W-1:DIV_Q_W]) >= req.denom;
            step_reg <= DIV_STEP_W'(DIV_Q_W);
        end
        else if (busy_reg)
        begin
            if (done)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= DIV_D_W'(req.numer[DIV_N_W-1:DIV_Q_W]);
            nlo_reg  <= req.numer[DIV_Q_W-1:0];
            den_reg  <= req.denom;
            quot_reg <= '0;
        end
        else if (busy_reg && !done)
        begin
            rem_reg  <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            nlo_reg  <= {nlo_reg[DIV_Q_W-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_Q_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

/* rtl/core/gisc_store.sv */
// Sensor store: timestamps and fired flags of one run, load slot and fired count.
// Depends on gisc_pkg.
`default_nettype none

module gisc_store
    import gisc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire store_wr_t         wr,
    input  wire logic [SLOT_W-1:0] rd_addr,
    output logic [TS_W-1:0]        rd_ts,
    output logic                   rd_fired,
    output store_stat_t            stat
);

    logic [TS_W-1:0]   ts_reg    [SENSOR_COUNT];
    logic              fired_reg [SENSOR_COUNT];
    logic [SLOT_W-1:0] load_idx_reg;
    logic [TRIG_W-1:0] trig_reg;
    logic              at_last;

    assign at_last         = load_idx_reg == SLOT_W'(SENSOR_COUNT - 1);
    assign stat.at_last    = at_last;
    assign stat.trig_count = trig_reg;
    assign rd_ts           = ts_reg[rd_addr];
    assign rd_fired        = fired_reg[rd_addr];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            ts_reg[load_idx_reg]    <= wr.ts;
            fired_reg[load_idx_reg] <= wr.fired;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_idx_reg <= '0;
            trig_reg     <= '0;
        end
        else if (wr.en)
        begin
            // the last slot closes the run
            if (at_last)
            begin
                load_idx_reg <= '0;
                trig_reg     <= '0;
            end
            else
            begin
                load_idx_reg <= load_idx_reg + 1'b1;
                trig_reg     <= trig_reg + TRIG_W'(wr.fired);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/gate_interval_speed_calc.sv */
// Channel  | Direction | Handshake            | Beat
// ---------+-----------+----------------------+-------------------------------
// in       | input     | in_valid / in_ready  | in_t: one sensor, physical order
// out      | output    | out_valid / out_ready| out_t: interval or run summary
// cfg      | input     | cfg_valid / cfg_ready| register index and write data
//
// Every beat but the last of a run is stored and the block stays idle. The last beat
// starts evaluation: Q16 product setup (S_MUL0 to S_MUL3), a walk over the sensors, then
// per interval two passes through the shared 24-step divider (shorter when the quotient
// saturates) and an emit state, and finally average and summary. in_ready stays low
// meanwhile.
// Reset clears control and restores register defaults; stores need no clearing.
// A stalled out channel holds evaluation at the next result; cfg_ready is always high.
`default_nettype none
`include "gate_interval_speed_calc_macros.svh"

module gate_interval_speed_calc
    import gisc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_t                  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_t                      out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MUL0     = 4'd1;
    localparam logic [3:0] S_MUL1     = 4'd2;
    localparam logic [3:0] S_MUL2     = 4'd3;
    localparam logic [3:0] S_MUL3     = 4'd4;
    localparam logic [3:0] S_WALK     = 4'd5;
    localparam logic [3:0] S_SPD_GO   = 4'd6;
    localparam logic [3:0] S_SPD_WAIT = 4'd7;
    localparam logic [3:0] S_MPH_GO   = 4'd8;
    localparam logic [3:0] S_MPH_WAIT = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;
    localparam logic [3:0] S_SUM      = 4'd11;
    localparam logic [3:0] S_AVG_WAIT = 4'd12;
    localparam logic [3:0] S_SEMIT    = 4'd13;

    logic [3:0]           state_reg;
    logic                 out_valid_reg;
    out_t                 out_data_reg;
    logic [SPACING_W-1:0] spacing_reg;
    logic [MPHQ_W-1:0]    mphq_reg;
    logic [IVL_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     mph_sum_reg;
    logic [SLOT_W-1:0]    walk_reg;

    logic                 dir_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [PP_W-1:0]      mlo_reg;
    logic [PP_W-1:0]      mhi_reg;
    logic [DIV_N_W-1:0]   mnum_reg;
    logic [TS_W-1:0]      prev_ts_reg;
    logic                 prev_fired_reg;
    logic [TS_W-1:0]      dt_reg;
    logic                 walk_end_reg;
    logic [SPD_W-1:0]     spd_reg;
    logic [SPD_W-1:0]     mph_reg;
    logic [SPD_W-1:0]     avg_reg;

    logic                 in_accept;
    logic                 out_free;
    logic                 out_load;
    out_t                 out_next;
    logic [TRIG_SUM_W-1:0] trig_total;
    logic                 run_has_pairs;
    logic                 walk_at_end;
    logic [TS_W-1:0]      dt;
    logic                 pair_ok;
    logic [HI_W-1:0]      mul_a;
    logic [PP_W-1:0]      mul_out;
    logic [PROD_W-1:0]    prod_sum;

    store_wr_t            store_wr;
    store_stat_t          store_stat;
    logic [SLOT_W-1:0]    rd_addr;
    logic [TS_W-1:0]      rd_ts;
    logic                 rd_fired;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    assign in_ready  = state_reg == S_IDLE;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = ((state_reg == S_EMIT) || (state_reg == S_SEMIT)) && out_free;

    assign store_wr.en    = in_accept;
    assign store_wr.ts    = in_data.timestamp_us;
    assign store_wr.fired = in_data.sensor_triggered;

    assign trig_total    = {1'b0, store_stat.trig_count}
                         + TRIG_SUM_W'(in_data.sensor_triggered);
    assign run_has_pairs = trig_total >= TRIG_SUM_W'(2);

    // travel order: reverse the physical order for B to A
    assign rd_addr     = dir_reg ? SLOT_W'(SENSOR_COUNT - 1) - walk_reg : walk_reg;
    assign walk_at_end = walk_reg == SLOT_W'(SENSOR_COUNT - 1);
    assign dt          = rd_ts - prev_ts_reg;
    assign pair_ok     = (walk_reg != '0) && rd_fired && prev_fired_reg && (dt != '0);

    assign mul_a    = (state_reg == S_MUL1) ? HI_W'(num_reg[HALF_W-1:0])
                                            : num_reg[NUM_W-1:HALF_W];
    assign mul_out  = PP_W'(mul_a) * PP_W'(mphq_reg);
    assign prod_sum = PROD_W'(mlo_reg) + (PROD_W'(mhi_reg) << HALF_W);

    gisc_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (store_wr),
        .rd_addr  (rd_addr),
        .rd_ts    (rd_ts),
        .rd_fired (rd_fired),
        .stat     (store_stat)
    );

    gisc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.numer = DIV_N_W'(num_reg);
        div_req.denom = dt_reg;
        if (state_reg == S_SPD_GO)
        begin
            div_req.start = 1'b1;
        end
        else if (state_reg == S_MPH_GO)
        begin
            div_req.start = 1'b1;
            div_req.numer = mnum_reg;
        end
        else if (state_reg == S_SUM)
        begin
            div_req.start = cnt_reg != '0;
            div_req.numer = DIV_N_W'(mph_sum_reg);
            div_req.denom = DIV_D_W'(cnt_reg);
        end
    end

    always_comb
    begin
        out_next = '0;
        if (state_reg == S_SEMIT)
        begin
            out_next.is_summary     = 1'b1;
            out_next.interval_count = cnt_reg;
            out_next.avg_mph_x256   = avg_reg;
            out_next.run_ok         = cnt_reg != '0;
            out_next.last_result    = 1'b1;
        end
        else
        begin
            out_next.interval_us    = dt_reg;
            out_next.speed_mm_per_s = spd_reg;
            out_next.scale_mph_x256 = mph_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            spacing_reg   <= SPACING_RST;
            mphq_reg      <= MPHQ_RST;
            cnt_reg       <= '0;
            mph_sum_reg   <= '0;
            walk_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SPACING: spacing_reg <= cfg_data[SPACING_W-1:0];
                    CFG_MPH:     mphq_reg    <= cfg_data[MPHQ_W-1:0];
                    default:     ;
                endcase
            end

            out_valid_reg <= out_load || (out_valid_reg && !out_ready);

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && store_stat.at_last)
                        state_reg <= run_has_pairs ? S_MUL0 : S_SUM;
                end
                S_MUL0: state_reg <= S_MUL1;
                S_MUL1: state_reg <= S_MUL2;
                S_MUL2: state_reg <= S_MUL3;
                S_MUL3:
                begin
                    walk_reg  <= '0;
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (!walk_at_end)
                        walk_reg <= walk_reg + 1'b1;
                    if (pair_ok)
                        state_reg <= S_SPD_GO;
                    else if (walk_at_end)
                        state_reg <= S_SUM;
                end
                S_SPD_GO: state_reg <= S_SPD_WAIT;
                S_SPD_WAIT:
                begin
                    if (div_rsp.done)
                        state_reg <= S_MPH_GO;
                end
                S_MPH_GO: state_reg <= S_MPH_WAIT;
                S_MPH_WAIT:
                begin
                    if (div_rsp.done)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        cnt_reg     <= cnt_reg + 1'b1;
                        mph_sum_reg <= mph_sum_reg + SUM_W'(mph_reg);
                        state_reg   <= walk_end_reg ? S_SUM : S_WALK;
                    end
                end
                S_SUM: state_reg <= (cnt_reg == '0) ? S_SEMIT : S_AVG_WAIT;
                S_AVG_WAIT:
                begin
                    if (div_rsp.done)
                        state_reg <= S_SEMIT;
                end
                S_SEMIT:
                begin
                    if (out_free)
                    begin
                        cnt_reg     <= '0;
                        mph_sum_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && store_stat.at_last)
            dir_reg <= in_data.travel_b_to_a;
        if (state_reg == S_MUL0)
            num_reg <= NUM_W'(spacing_reg) * NUM_W'(US_PER_S);
        if (state_reg == S_MUL1)
            mlo_reg <= mul_out;
        if (state_reg == S_MUL2)
            mhi_reg <= mul_out;
        // shift out 8 of the Q16 factor's fraction bits so the quotient comes out x256
        if (state_reg == S_MUL3)
            mnum_reg <= prod_sum[PROD_W-1:MPH_SHIFT];
        if (state_reg == S_WALK)
        begin
            prev_ts_reg    <= rd_ts;
            prev_fired_reg <= rd_fired;
            dt_reg         <= dt;
            walk_end_reg   <= walk_at_end;
        end
        if ((state_reg == S_SPD_WAIT) && div_rsp.done)
            spd_reg <= div_rsp.quot;
        if ((state_reg == S_MPH_WAIT) && div_rsp.done)
            mph_reg <= div_rsp.quot;
        if ((state_reg == S_AVG_WAIT) && div_rsp.done)
            avg_reg <= div_rsp.quot;
        if ((state_reg == S_SUM) && (cnt_reg == '0))
            avg_reg <= '0;
        if (out_load)
            out_data_reg <= out_next;
    end

    `GISC_ASSERT_NOW(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
    `GISC_ASSERT_NOW(a_out_no_overwrite, out_load, !out_valid_reg || out_ready, "result overwritten")
    `GISC_ASSERT_NEXT(a_mid_run_idle, in_accept && !store_stat.at_last, state_reg == S_IDLE, "mid-run beat left idle")
    `GISC_ASSERT_NOW(a_cnt_bound, state_reg == S_SEMIT, cnt_reg <= IVL_CNT_W'(SENSOR_COUNT - 1), "interval count overflow")

endmodule

`default_nettype wire
